// ===== rtl/core/tss_pkg.sv =====
// shared types and constants for the three-sum search block
package tss_pkg;

  localparam int unsigned DATA_W = 32;

  // datapath commands, one per controller step
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CHECK,
    CMD_SORT_INIT,
    CMD_BUILD_SET,
    CMD_SD_START,
    CMD_SD_ROOT,
    CMD_SD_LEFT,
    CMD_SD_RIGHT,
    CMD_SD_DECIDE,
    CMD_SD_SWAP,
    CMD_EX_RD0,
    CMD_EX_RDL,
    CMD_EX_W0,
    CMD_EX_WL,
    CMD_SC_INIT,
    CMD_SC_ROW,
    CMD_SC_RDJ,
    CMD_SC_RDK,
    CMD_SC_CAPK,
    CMD_SC_CMP,
    CMD_SC_LDJ,
    CMD_SC_LDK
  } cmd_e;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SORT_INIT,
    ST_BUILD_SET,
    ST_SD_START,
    ST_SD_ROOT,
    ST_SD_LEFT,
    ST_SD_RIGHT,
    ST_SD_DECIDE,
    ST_SD_SWAP,
    ST_EX_RD0,
    ST_EX_RDL,
    ST_EX_W0,
    ST_EX_WL,
    ST_SC_INIT,
    ST_SC_ROW,
    ST_SC_RDJ,
    ST_SC_RDK,
    ST_SC_CAPK,
    ST_SC_CMP,
    ST_SC_LDJ,
    ST_SC_LDK
  } state_e;

  // datapath status seen by the controller
  typedef struct packed {
    logic cnt_ge3;
    logic idx_zero;
    logic extract;
    logic hsz_gt1;
    logic big_is_root;
    logic row_end;
    logic pair_done;
    logic sum_eq;
    logic sum_gt;
  } status_t;

endpackage

// ===== rtl/core/tss_ram.sv =====
// generic single write, single read ram with registered read data
module tss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tss_ctrl.sv =====
// controller state machine sequencing load, heapsort and two-pointer scan
module tss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             is_last_i,
  input  tss_pkg::status_t status_i,
  output tss_pkg::cmd_e    cmd_o,
  output logic             busy_o
);

  tss_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = tss_pkg::CMD_NONE;
    busy_o  = 1'b1;
    case (state_q)
      tss_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o = tss_pkg::CMD_LOAD;
          if (is_last_i) begin
            state_d = tss_pkg::ST_CHECK;
          end
        end
      end
      tss_pkg::ST_CHECK: begin
        cmd_o   = tss_pkg::CMD_CHECK;
        state_d = status_i.cnt_ge3 ? tss_pkg::ST_SORT_INIT : tss_pkg::ST_IDLE;
      end
      tss_pkg::ST_SORT_INIT: begin
        cmd_o   = tss_pkg::CMD_SORT_INIT;
        state_d = tss_pkg::ST_BUILD_SET;
      end
      tss_pkg::ST_BUILD_SET: begin
        cmd_o   = tss_pkg::CMD_BUILD_SET;
        state_d = tss_pkg::ST_SD_START;
      end
      tss_pkg::ST_SD_START: begin
        cmd_o   = tss_pkg::CMD_SD_START;
        state_d = tss_pkg::ST_SD_ROOT;
      end
      tss_pkg::ST_SD_ROOT: begin
        cmd_o   = tss_pkg::CMD_SD_ROOT;
        state_d = tss_pkg::ST_SD_LEFT;
      end
      tss_pkg::ST_SD_LEFT: begin
        cmd_o   = tss_pkg::CMD_SD_LEFT;
        state_d = tss_pkg::ST_SD_RIGHT;
      end
      tss_pkg::ST_SD_RIGHT: begin
        cmd_o   = tss_pkg::CMD_SD_RIGHT;
        state_d = tss_pkg::ST_SD_DECIDE;
      end
      tss_pkg::ST_SD_DECIDE: begin
        cmd_o = tss_pkg::CMD_SD_DECIDE;
        if (!status_i.big_is_root) begin
          state_d = tss_pkg::ST_SD_SWAP;
        end else if (status_i.extract) begin
          state_d = status_i.hsz_gt1 ? tss_pkg::ST_EX_RD0 : tss_pkg::ST_SC_INIT;
        end else begin
          state_d = status_i.idx_zero ? tss_pkg::ST_EX_RD0 : tss_pkg::ST_BUILD_SET;
        end
      end
      tss_pkg::ST_SD_SWAP: begin
        cmd_o   = tss_pkg::CMD_SD_SWAP;
        state_d = tss_pkg::ST_SD_LEFT;
      end
      tss_pkg::ST_EX_RD0: begin
        cmd_o   = tss_pkg::CMD_EX_RD0;
        state_d = tss_pkg::ST_EX_RDL;
      end
      tss_pkg::ST_EX_RDL: begin
        cmd_o   = tss_pkg::CMD_EX_RDL;
        state_d = tss_pkg::ST_EX_W0;
      end
      tss_pkg::ST_EX_W0: begin
        cmd_o   = tss_pkg::CMD_EX_W0;
        state_d = tss_pkg::ST_EX_WL;
      end
      tss_pkg::ST_EX_WL: begin
        cmd_o   = tss_pkg::CMD_EX_WL;
        state_d = tss_pkg::ST_SD_START;
      end
      tss_pkg::ST_SC_INIT: begin
        cmd_o   = tss_pkg::CMD_SC_INIT;
        state_d = tss_pkg::ST_SC_ROW;
      end
      tss_pkg::ST_SC_ROW: begin
        cmd_o   = tss_pkg::CMD_SC_ROW;
        state_d = status_i.row_end ? tss_pkg::ST_IDLE : tss_pkg::ST_SC_RDJ;
      end
      tss_pkg::ST_SC_RDJ: begin
        cmd_o   = tss_pkg::CMD_SC_RDJ;
        state_d = tss_pkg::ST_SC_RDK;
      end
      tss_pkg::ST_SC_RDK: begin
        cmd_o   = tss_pkg::CMD_SC_RDK;
        state_d = tss_pkg::ST_SC_CAPK;
      end
      tss_pkg::ST_SC_CAPK: begin
        cmd_o   = tss_pkg::CMD_SC_CAPK;
        state_d = tss_pkg::ST_SC_CMP;
      end
      tss_pkg::ST_SC_CMP: begin
        cmd_o = tss_pkg::CMD_SC_CMP;
        if (status_i.pair_done) begin
          state_d = tss_pkg::ST_SC_ROW;
        end else if (status_i.sum_eq) begin
          state_d = tss_pkg::ST_IDLE;
        end else if (status_i.sum_gt) begin
          state_d = tss_pkg::ST_SC_LDK;
        end else begin
          state_d = tss_pkg::ST_SC_LDJ;
        end
      end
      tss_pkg::ST_SC_LDJ: begin
        cmd_o   = tss_pkg::CMD_SC_LDJ;
        state_d = tss_pkg::ST_SC_CMP;
      end
      tss_pkg::ST_SC_LDK: begin
        cmd_o   = tss_pkg::CMD_SC_LDK;
        state_d = tss_pkg::ST_SC_CMP;
      end
      default: begin
        state_d = tss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/tss_datapath.sv =====
// datapath: element store, heap and scan pointers, sum compare, result registers
module tss_datapath #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tss_pkg::cmd_e                     cmd_i,
  output tss_pkg::status_t                  status_o,
  input  logic signed [tss_pkg::DATA_W-1:0] element_i,
  input  logic signed [tss_pkg::DATA_W-1:0] target_sum_i,
  input  logic                              is_last_i,
  output logic                              done_o,
  output logic                              found_o,
  output logic signed [tss_pkg::DATA_W-1:0] first_value_o,
  output logic signed [tss_pkg::DATA_W-1:0] second_value_o,
  output logic signed [tss_pkg::DATA_W-1:0] third_value_o,
  output logic                              overflowed_o
);

  localparam int unsigned DW = tss_pkg::DATA_W;
  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned HW = AW + 2;
  localparam int unsigned SW = DW + 2;

  // control registers
  logic [CW-1:0] count_q;
  logic          ovf_q;
  logic          done_q;

  // heap and scan registers
  logic [DW-1:0] target_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] hsz_q;
  logic          extract_q;
  logic [AW-1:0] root_q;
  logic [AW-1:0] big_q;
  logic [DW-1:0] vroot_q;
  logic [DW-1:0] vbig_q;
  logic [AW-1:0] i_q;
  logic [AW-1:0] j_q;
  logic [AW-1:0] k_q;
  logic [DW-1:0] vi_q;
  logic [DW-1:0] vj_q;
  logic [DW-1:0] vk_q;

  // result registers
  logic          found_q;
  logic [DW-1:0] r0_q;
  logic [DW-1:0] r1_q;
  logic [DW-1:0] r2_q;
  logic          rovf_q;

  // ram port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] rdata;

  // derived values
  logic [HW-1:0]        left_w;
  logic [HW-1:0]        right_w;
  logic [HW-1:0]        big_left_w;
  logic                 left_lt;
  logic                 right_lt;
  logic                 rd_gt_big;
  logic                 cnt_full;
  logic [CW-1:0]        idx_m1;
  logic [CW-1:0]        hsz_m1;
  logic [CW-1:0]        cnt_m1;
  logic signed [SW-1:0] sum_w;
  logic signed [SW-1:0] target_w;
  logic                 report_none;
  logic                 report_found;
  tss_pkg::status_t     status;

  tss_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_ELEMENTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  // heap child indices and bounds
  assign left_w     = {1'b0, root_q, 1'b1};
  assign right_w    = left_w + HW'(1);
  assign big_left_w = {1'b0, big_q, 1'b1};
  assign left_lt    = left_w < HW'(hsz_q);
  assign right_lt   = right_w < HW'(hsz_q);
  assign rd_gt_big  = $signed(vbig_q) < $signed(rdata);
  assign cnt_full   = count_q == CW'(MAX_ELEMENTS);
  assign idx_m1     = idx_q - CW'(1);
  assign hsz_m1     = hsz_q - CW'(1);
  assign cnt_m1     = count_q - CW'(1);

  // wide triple sum, no wrap
  assign sum_w = SW'($signed(vi_q)) + SW'($signed(vj_q)) + SW'($signed(vk_q));
  assign target_w = SW'($signed(target_q));

  // status towards the controller
  always_comb begin
    status.cnt_ge3     = count_q >= CW'(3);
    status.idx_zero    = idx_q == '0;
    status.extract     = extract_q;
    status.hsz_gt1     = hsz_q > CW'(1);
    status.big_is_root = big_q == root_q;
    status.row_end     = (HW'(i_q) + HW'(2)) >= HW'(count_q);
    status.pair_done   = j_q >= k_q;
    status.sum_eq      = sum_w == target_w;
    status.sum_gt      = sum_w > target_w;
  end

  assign status_o = status;

  // report decisions
  assign report_none = ((cmd_i == tss_pkg::CMD_CHECK) && !status.cnt_ge3) ||
                       ((cmd_i == tss_pkg::CMD_SC_ROW) && status.row_end);
  assign report_found = (cmd_i == tss_pkg::CMD_SC_CMP) && !status.pair_done &&
                        status.sum_eq;

  // store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = root_q;
    ram_wdata = vroot_q;
    ram_raddr = root_q;
    case (cmd_i)
      tss_pkg::CMD_LOAD: begin
        ram_we    = !cnt_full;
        ram_waddr = count_q[AW-1:0];
        ram_wdata = element_i;
      end
      tss_pkg::CMD_SD_START: begin
        ram_raddr = root_q;
      end
      tss_pkg::CMD_SD_ROOT: begin
        ram_raddr = left_w[AW-1:0];
      end
      tss_pkg::CMD_SD_LEFT: begin
        ram_raddr = right_w[AW-1:0];
      end
      tss_pkg::CMD_SD_DECIDE: begin
        ram_we    = !status.big_is_root;
        ram_waddr = root_q;
        ram_wdata = vbig_q;
      end
      tss_pkg::CMD_SD_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = big_q;
        ram_wdata = vroot_q;
        ram_raddr = big_left_w[AW-1:0];
      end
      tss_pkg::CMD_EX_RD0: begin
        ram_raddr = '0;
      end
      tss_pkg::CMD_EX_RDL: begin
        ram_raddr = hsz_m1[AW-1:0];
      end
      tss_pkg::CMD_EX_W0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = rdata;
      end
      tss_pkg::CMD_EX_WL: begin
        ram_we    = 1'b1;
        ram_waddr = hsz_m1[AW-1:0];
        ram_wdata = vroot_q;
      end
      tss_pkg::CMD_SC_ROW: begin
        ram_raddr = i_q;
      end
      tss_pkg::CMD_SC_RDJ: begin
        ram_raddr = j_q;
      end
      tss_pkg::CMD_SC_RDK: begin
        ram_raddr = k_q;
      end
      tss_pkg::CMD_SC_CMP: begin
        ram_raddr = status.sum_gt ? (k_q - AW'(1)) : (j_q + AW'(1));
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // fill count, overflow flag and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= report_none || report_found;
      if (report_none || report_found) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i == tss_pkg::CMD_LOAD) begin
        if (cnt_full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
        end
      end
    end
  end

  // heap and scan working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      tss_pkg::CMD_LOAD: begin
        if (is_last_i) begin
          target_q <= target_sum_i;
        end
      end
      tss_pkg::CMD_SORT_INIT: begin
        idx_q     <= count_q >> 1;
        hsz_q     <= count_q;
        extract_q <= 1'b0;
      end
      tss_pkg::CMD_BUILD_SET: begin
        root_q <= idx_m1[AW-1:0];
        idx_q  <= idx_m1;
      end
      tss_pkg::CMD_SD_ROOT: begin
        vroot_q <= rdata;
        vbig_q  <= rdata;
        big_q   <= root_q;
      end
      tss_pkg::CMD_SD_LEFT: begin
        if (left_lt && rd_gt_big) begin
          big_q  <= left_w[AW-1:0];
          vbig_q <= rdata;
        end
      end
      tss_pkg::CMD_SD_RIGHT: begin
        if (right_lt && rd_gt_big) begin
          big_q  <= right_w[AW-1:0];
          vbig_q <= rdata;
        end
      end
      tss_pkg::CMD_SD_SWAP: begin
        root_q <= big_q;
        vbig_q <= vroot_q;
      end
      tss_pkg::CMD_EX_RD0: begin
        extract_q <= 1'b1;
      end
      tss_pkg::CMD_EX_RDL: begin
        vroot_q <= rdata;
      end
      tss_pkg::CMD_EX_WL: begin
        hsz_q  <= hsz_m1;
        root_q <= '0;
      end
      tss_pkg::CMD_SC_INIT: begin
        i_q <= '0;
      end
      tss_pkg::CMD_SC_ROW: begin
        j_q <= i_q + AW'(1);
        k_q <= cnt_m1[AW-1:0];
      end
      tss_pkg::CMD_SC_RDJ: begin
        vi_q <= rdata;
      end
      tss_pkg::CMD_SC_RDK: begin
        vj_q <= rdata;
      end
      tss_pkg::CMD_SC_CAPK: begin
        vk_q <= rdata;
      end
      tss_pkg::CMD_SC_CMP: begin
        if (status.pair_done) begin
          i_q <= i_q + AW'(1);
        end else if (!status.sum_eq) begin
          if (status.sum_gt) begin
            k_q <= k_q - AW'(1);
          end else begin
            j_q <= j_q + AW'(1);
          end
        end
      end
      tss_pkg::CMD_SC_LDJ: begin
        vj_q <= rdata;
      end
      tss_pkg::CMD_SC_LDK: begin
        vk_q <= rdata;
      end
      default: begin
        idx_q <= idx_q;
      end
    endcase
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (report_found) begin
      found_q <= 1'b1;
      r0_q    <= vi_q;
      r1_q    <= vj_q;
      r2_q    <= vk_q;
      rovf_q  <= ovf_q;
    end else if (report_none) begin
      found_q <= 1'b0;
      r0_q    <= '0;
      r1_q    <= '0;
      r2_q    <= '0;
      rovf_q  <= ovf_q;
    end
  end

  assign done_o         = done_q;
  assign found_o        = found_q;
  assign first_value_o  = r0_q;
  assign second_value_o = r1_q;
  assign third_value_o  = r2_q;
  assign overflowed_o   = rovf_q;

endmodule

// ===== rtl/core/three_sum_search_top.sv =====
// top level of the three-sum search block
// Usage: the block takes one element per item on start_i when busy_o is low.
// Items without is_last_i are stored one per cycle and busy_o stays low.
// Elements past MAX_ELEMENTS are dropped and flagged in overflowed_o.
// The item with is_last_i also stores its element and carries target_sum_i;
// busy_o then rises while the set is sorted and scanned.
// After the last item the set is heapsorted, first building the heap by
// sift-down passes and then extracting its root into the tail, and is
// then scanned with a left and a right pointer for each first index; the
// store has one read and one write port, and one read per cycle sets the
// pace. Sets under three elements answer without a sort or a scan.
// The result is shown for one cycle with done_o high, and busy_o is low in
// that cycle, so the next set may start at once. The receiver cannot stall:
// done_o is a strobe and the result ports hold until the next result.
// Reset clears the fill count, the overflow flag and the controller; the
// stored elements are not cleared and need no clearing pass.
module three_sum_search_top #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [tss_pkg::DATA_W-1:0] element_i,
  input  logic signed [tss_pkg::DATA_W-1:0] target_sum_i,
  input  logic                              is_last_i,
  output logic                              done_o,
  output logic                              found_o,
  output logic signed [tss_pkg::DATA_W-1:0] first_value_o,
  output logic signed [tss_pkg::DATA_W-1:0] second_value_o,
  output logic signed [tss_pkg::DATA_W-1:0] third_value_o,
  output logic                              overflowed_o
);

  tss_pkg::cmd_e    cmd;
  tss_pkg::status_t status;

  // sequencer
  tss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .is_last_i(is_last_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // store, pointers and result registers
  tss_datapath #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .element_i     (element_i),
    .target_sum_i  (target_sum_i),
    .is_last_i     (is_last_i),
    .done_o        (done_o),
    .found_o       (found_o),
    .first_value_o (first_value_o),
    .second_value_o(second_value_o),
    .third_value_o (third_value_o),
    .overflowed_o  (overflowed_o)
  );

`ifndef SYNTHESIS
  // a result always leaves the block ready for the next set
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // one result per set
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

  // an item that is not last never produces a result
  a_no_mid_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !is_last_i) |=> !done_o)
    else $error("result after an item that was not last");

  // a miss reports zero values
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (first_value_o == '0 && second_value_o == '0 &&
                              third_value_o == '0))
    else $error("miss with non-zero values");
`endif

endmodule
